@@ sv/wsinc_pkg.sv @@
// ----------------------------------------------------------------------------
// wsinc_pkg: shared types and constants of the windowed-sinc generator
// Holds the sequencer state type, register indexes, fixed widths, the
// CORDIC arctangent table and the fixed-point constants of pi.
// ----------------------------------------------------------------------------
package wsinc_pkg;

    localparam int TAP_W    = 12;   // tap counter
    localparam int PER_W    = 7;    // sinc_period register
    localparam int LOB_W    = 5;    // lobe_count register
    localparam int CFG_W    = 7;    // configuration write data
    localparam int SAMPLE_W = 16;   // Q1.15 samples and coefficients

    // Configuration register indexes.
    localparam logic REG_SINC_PERIOD = 1'b0;
    localparam logic REG_LOBE_COUNT  = 1'b1;

    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 34;   // CORDIC x, y, z width, Q2.30 with headroom

    localparam logic [30:0] PI_Q29          = 31'd1686629713;
    localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

    // Truncated arctangent of 2^-k in Q2.30.
    function automatic logic [29:0] atan_q30(input logic [4:0] k);
        logic [29:0] v;
        case (k)
            5'd0:    v = 30'h3243F6A8;
            5'd1:    v = 30'h1DAC6705;
            5'd2:    v = 30'h0FADBAFC;
            5'd3:    v = 30'h07F56EA6;
            5'd4:    v = 30'h03FEAB76;
            5'd5:    v = 30'h01FFD55B;
            5'd6:    v = 30'h00FFFAAA;
            5'd7:    v = 30'h007FFF55;
            5'd8:    v = 30'h003FFFEA;
            5'd9:    v = 30'h001FFFFD;
            5'd10:   v = 30'h000FFFFF;
            5'd11:   v = 30'h0007FFFF;
            5'd12:   v = 30'h0003FFFF;
            5'd13:   v = 30'h0001FFFF;
            5'd14:   v = 30'h0000FFFF;
            5'd15:   v = 30'h00007FFF;
            5'd16:   v = 30'h00003FFF;
            5'd17:   v = 30'h00001FFF;
            5'd18:   v = 30'h00000FFF;
            5'd19:   v = 30'h000007FF;
            5'd20:   v = 30'h000003FF;
            5'd21:   v = 30'h000001FF;
            5'd22:   v = 30'h000000FF;
            5'd23:   v = 30'h0000007F;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_MOD    = 14'b00000000000010,
        S_TURN   = 14'b00000000000100,
        S_MULZ   = 14'b00000000001000,
        S_ZINIT  = 14'b00000000010000,
        S_CORDIC = 14'b00000000100000,
        S_SINE   = 14'b00000001000000,
        S_MULN   = 14'b00000010000000,
        S_MULD   = 14'b00000100000000,
        S_DLOAD  = 14'b00001000000000,
        S_SINC   = 14'b00010000000000,
        S_MULW   = 14'b00100000000000,
        S_ROUND  = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } state_t;

endpackage

@@ sv/windowed_sinc_lowpass_coefficients_top.sv @@
// ----------------------------------------------------------------------------
// windowed_sinc_lowpass_coefficients_top: windowed-sinc lowpass FIR taps
// Multiplies each incoming window sample by sin(pi*n/N)/(pi*n/N), using a
// shared restoring divider, a rotation CORDIC and one shared multiplier.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer contents
//  s_*       in         tdata[15:0] window_sample
//  m_*       out        tdata[15:0] coefficient, tlast last_tap
//  cfg_*     in         cfg_addr 0 sinc_period, 1 lobe_count; no read-back
//
//  An ordinary tap passes from transfer to result through 12 divider steps
//  for the phase modulo, 32 for the phase fraction, 24 CORDIC steps, 17
//  divider steps for the sinc quotient and the multiply, load and rounding
//  states, which the centre and final taps skip. One tap is in flight at a
//  time; a new one is taken while the previous result waits in the output
//  register. Reset returns the tap counter to zero and the registers to 8, 4.
// ----------------------------------------------------------------------------
module windowed_sinc_lowpass_coefficients_top
    import wsinc_pkg::*;
#(
    parameter int MAX_LENGTH = 2049
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,     // [15:0] window_sample
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,     // [15:0] coefficient
    output logic                m_tlast,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    localparam int DIV_W      = 43;     // divisor and remainder width
    localparam int DVD_W      = 17;     // dividend shift register width
    localparam int ITER_W     = 6;
    localparam int MOD_STEPS  = TAP_W;
    localparam int TURN_STEPS = 32;
    localparam int SINC_STEPS = DVD_W;
    localparam logic [TAP_W:0] END_MAX = (TAP_W+1)'(MAX_LENGTH - 1);

    state_t                       state_reg, state_next;
    logic [TAP_W-1:0]             tap_reg, tap_next;
    logic [PER_W-1:0]             period_reg, period_next;
    logic [LOB_W-1:0]             lobes_reg, lobes_next;
    logic                         out_valid_reg, out_valid_next;

    logic signed [SAMPLE_W-1:0]   w_reg, w_next;
    logic                         n_neg_reg, n_neg_next;
    logic [TAP_W-1:0]             mag_n_reg, mag_n_next;
    logic [DIV_W-1:0]             rem_reg, rem_next;
    logic [DIV_W-1:0]             div_reg, div_next;
    logic [DVD_W-1:0]             dvd_reg, dvd_next;
    logic [31:0]                  quo_reg, quo_next;
    logic [ITER_W-1:0]            iter_reg, iter_next;
    logic signed [63:0]           prod_reg, prod_next;
    logic signed [CW-1:0]         x_reg, x_next;
    logic signed [CW-1:0]         y_reg, y_next;
    logic signed [CW-1:0]         z_reg, z_next;
    logic [30:0]                  mag_s_reg, mag_s_next;
    logic                         neg_reg, neg_next;
    logic [37:0]                  num_reg, num_next;
    logic signed [SAMPLE_W-1:0]   c_reg, c_next;
    logic [SAMPLE_W-1:0]          res_coef_reg, res_coef_next;
    logic                         res_last_reg, res_last_next;
    logic [SAMPLE_W-1:0]          out_coef_reg, out_coef_next;
    logic                         out_last_reg, out_last_next;

    // Tap classification from the registers and the counter.
    logic [TAP_W-1:0]             centre;
    logic [TAP_W:0]               end_raw, end_lim;
    logic                         is_last, is_centre;
    logic signed [TAP_W:0]        n_diff;
    logic [TAP_W-1:0]             n_abs;
    logic [7:0]                   two_per;

    // Shared divider step.
    logic [DIV_W:0]               trial;
    logic                         step_ge;
    logic [DIV_W-1:0]             step_rem;

    // Shared multiplier.
    logic signed [32:0]           mul_a, mul_b;
    logic signed [65:0]           mul_prod;

    // CORDIC step.
    logic signed [CW-1:0]         cd_dx, cd_dy, cd_atan;

    // Local results.
    logic [7:0]                   mod_r;
    logic signed [CW-1:0]         sine, sine_abs;
    logic [DIV_W-1:0]             den;
    logic [52:0]                  dsum;
    logic [16:0]                  q_sinc;
    logic signed [32:0]           rnd;
    logic signed [17:0]           rnd_sh;

    assign centre    = TAP_W'(lobes_reg) * TAP_W'(period_reg);
    assign end_raw   = {centre, 1'b0};
    assign end_lim   = (end_raw > END_MAX) ? END_MAX : end_raw;
    assign is_last   = {1'b0, tap_reg} >= end_lim;
    assign is_centre = tap_reg == centre;
    assign n_diff    = {1'b0, tap_reg} - {1'b0, centre};
    assign n_abs     = n_diff[TAP_W] ? TAP_W'(-n_diff) : n_diff[TAP_W-1:0];
    assign two_per   = {period_reg, 1'b0};

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign step_ge  = trial >= {1'b0, div_reg};
    assign step_rem = step_ge ? DIV_W'(trial - {1'b0, div_reg}) : DIV_W'(trial);

    assign cd_dx   = y_reg >>> iter_reg[4:0];
    assign cd_dy   = x_reg >>> iter_reg[4:0];
    assign cd_atan = CW'(atan_q30(iter_reg[4:0]));

    assign mod_r    = (n_neg_reg && (step_rem[7:0] != 8'd0)) ? two_per - step_rem[7:0]
                                                             : step_rem[7:0];
    assign den      = prod_reg[DIV_W-1:0];
    assign dsum     = {1'b0, num_reg, 14'b0} + 53'(den >> 1);
    assign q_sinc   = {quo_reg[15:0], step_ge};
    assign rnd      = {prod_reg[31], prod_reg[31:0]} + 33'sd16384;
    assign rnd_sh   = rnd[32:15];

    always_comb
    begin
        case (quo_reg[31:30])
            2'd0:    sine = y_reg;
            2'd1:    sine = x_reg;
            2'd2:    sine = -y_reg;
            default: sine = -x_reg;
        endcase
        sine_abs = sine[CW-1] ? -sine : sine;
    end

    always_comb
    begin
        case (state_reg)
            S_MULZ:
            begin
                mul_a = {3'b0, quo_reg[29:0]};
                mul_b = {2'b0, HALF_PI_Q30};
            end
            S_MULN:
            begin
                mul_a = {2'b0, mag_s_reg};
                mul_b = {{(33-PER_W){1'b0}}, period_reg};
            end
            S_MULD:
            begin
                mul_a = {2'b0, PI_Q29};
                mul_b = {{(33-TAP_W){1'b0}}, mag_n_reg};
            end
            S_MULW:
            begin
                mul_a = {{(33-SAMPLE_W){w_reg[SAMPLE_W-1]}}, w_reg};
                mul_b = {{(33-SAMPLE_W){c_reg[SAMPLE_W-1]}}, c_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_coef_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        tap_next       = tap_reg;
        period_next    = period_reg;
        lobes_next     = lobes_reg;
        out_valid_next = out_valid_reg;
        w_next         = w_reg;
        n_neg_next     = n_neg_reg;
        mag_n_next     = mag_n_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        iter_next      = iter_reg;
        prod_next      = mul_prod[63:0];
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        mag_s_next     = mag_s_reg;
        neg_next       = neg_reg;
        num_next       = num_reg;
        c_next         = c_reg;
        res_coef_next  = res_coef_reg;
        res_last_next  = res_last_reg;
        out_coef_next  = out_coef_reg;
        out_last_next  = out_last_reg;

        if (cfg_we)
        begin
            case (cfg_addr)
                REG_SINC_PERIOD: period_next = cfg_wdata[PER_W-1:0];
                REG_LOBE_COUNT:  lobes_next  = cfg_wdata[LOB_W-1:0];
                default:         ;
            endcase
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    w_next        = s_tdata;
                    tap_next      = is_last ? '0 : tap_reg + 1'b1;
                    res_last_next = is_last;
                    if (is_last)
                    begin
                        res_coef_next = '0;
                        state_next    = S_DONE;
                    end
                    else if (is_centre)
                    begin
                        res_coef_next = s_tdata;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        n_neg_next = n_diff[TAP_W];
                        mag_n_next = n_abs;
                        rem_next   = '0;
                        div_next   = DIV_W'(two_per);
                        dvd_next   = {n_abs, {(DVD_W-TAP_W){1'b0}}};
                        iter_next  = ITER_W'(MOD_STEPS - 1);
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                rem_next  = step_rem;
                dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    // Phase fraction r / (2N) continues from the folded remainder.
                    rem_next   = DIV_W'(mod_r);
                    dvd_next   = '0;
                    iter_next  = ITER_W'(TURN_STEPS - 1);
                    state_next = S_TURN;
                end
            end
            S_TURN:
            begin
                rem_next  = step_rem;
                dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
                quo_next  = {quo_reg[30:0], step_ge};
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    state_next = S_MULZ;
                end
            end
            S_MULZ:
            begin
                state_next = S_ZINIT;
            end
            S_ZINIT:
            begin
                z_next     = CW'(prod_reg[60:30]);
                x_next     = CW'(CORDIC_GAIN_Q30);
                y_next     = '0;
                iter_next  = '0;
                state_next = S_CORDIC;
            end
            S_CORDIC:
            begin
                if (!z_reg[CW-1])
                begin
                    x_next = x_reg - cd_dx;
                    y_next = y_reg + cd_dy;
                    z_next = z_reg - cd_atan;
                end
                else
                begin
                    x_next = x_reg + cd_dx;
                    y_next = y_reg - cd_dy;
                    z_next = z_reg + cd_atan;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
                begin
                    state_next = S_SINE;
                end
            end
            S_SINE:
            begin
                mag_s_next = sine_abs[30:0];
                neg_next   = sine[CW-1] ^ n_neg_reg;
                state_next = S_MULN;
            end
            S_MULN:
            begin
                state_next = S_MULD;
            end
            S_MULD:
            begin
                num_next   = prod_reg[37:0];
                state_next = S_DLOAD;
            end
            S_DLOAD:
            begin
                // Rounded quotient: (num * 2^14 + den / 2) / den, below 2^17.
                rem_next   = DIV_W'(dsum[52:DVD_W]);
                dvd_next   = dsum[DVD_W-1:0];
                div_next   = den;
                iter_next  = ITER_W'(SINC_STEPS - 1);
                state_next = S_SINC;
            end
            S_SINC:
            begin
                rem_next  = step_rem;
                dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
                quo_next  = {quo_reg[30:0], step_ge};
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    if (neg_reg)
                    begin
                        c_next = (q_sinc > 17'd32768) ? 16'sh8000 : SAMPLE_W'(-q_sinc);
                    end
                    else
                    begin
                        c_next = (q_sinc > 17'd32767) ? 16'sh7FFF : q_sinc[15:0];
                    end
                    state_next = S_MULW;
                end
            end
            S_MULW:
            begin
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                if (rnd_sh > 18'sd32767)
                begin
                    res_coef_next = 16'h7FFF;
                end
                else if (rnd_sh < -18'sd32768)
                begin
                    res_coef_next = 16'h8000;
                end
                else
                begin
                    res_coef_next = rnd_sh[15:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_coef_next  = res_coef_reg;
                    out_last_next  = res_last_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tap_reg       <= '0;
            period_reg    <= PER_W'(8);
            lobes_reg     <= LOB_W'(4);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            period_reg    <= period_next;
            lobes_reg     <= lobes_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        n_neg_reg    <= n_neg_next;
        mag_n_reg    <= mag_n_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        dvd_reg      <= dvd_next;
        quo_reg      <= quo_next;
        iter_reg     <= iter_next;
        prod_reg     <= prod_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        mag_s_reg    <= mag_s_next;
        neg_reg      <= neg_next;
        num_reg      <= num_next;
        c_reg        <= c_next;
        res_coef_reg <= res_coef_next;
        res_last_reg <= res_last_next;
        out_coef_reg <= out_coef_next;
        out_last_reg <= out_last_next;
    end

endmodule

@@ tb/tb_windowed_sinc_lowpass_coefficients_top.sv @@
// ----------------------------------------------------------------------------
// tb_windowed_sinc_lowpass_coefficients_top: self-checking bench for the
// windowed-sinc coefficient generator
// Streams window samples through the block under several register settings
// and idle patterns. Every result is compared field by field against a
// bit-exact fixed-point model of the tap counter, CORDIC sine and divider.
// ----------------------------------------------------------------------------
module tb_windowed_sinc_lowpass_coefficients_top
    import wsinc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_LENGTH   = 2049;
    localparam int          HOLD_CYCLES  = 800;
    localparam int          DRAIN_CYCLES = 200;
    localparam int unsigned RANDOM_ITEMS = 1600;
    localparam int unsigned LONG_ITEMS   = 500;
    localparam int unsigned LIMIT_CYCLES = 2000000;

    localparam longint unsigned PI_Q29_TB      = 64'd1686629713;
    localparam longint unsigned HALF_PI_Q30_TB = 64'd1686629713;
    localparam longint          GAIN_Q30_TB    = 64'd652032874;

    // Truncated arctangent of 2^-k in Q2.30, element k at index k.
    localparam logic [23:0][31:0] ATAN_Q30_TB = {
        32'h0000007F, 32'h000000FF, 32'h000001FF, 32'h000003FF,
        32'h000007FF, 32'h00000FFF, 32'h00001FFF, 32'h00003FFF,
        32'h00007FFF, 32'h0000FFFF, 32'h0001FFFF, 32'h0003FFFF,
        32'h0007FFFF, 32'h000FFFFF, 32'h001FFFFD, 32'h003FFFEA,
        32'h007FFF55, 32'h00FFFAAA, 32'h01FFD55B, 32'h03FEAB76,
        32'h07F56EA6, 32'h0FADBAFC, 32'h1DAC6705, 32'h3243F6A8
    };

    typedef enum logic [1:0] {ENT_WINDOW, ENT_WRITE, ENT_PHASE, ENT_HOLD} entry_kind_t;

    typedef struct {
        entry_kind_t      kind;
        logic [15:0]      window;
        logic             addr;
        logic [CFG_W-1:0] value;
        int unsigned      gap_pct;
        int unsigned      stall_pct;
    } pending_t;

    typedef struct {
        logic [15:0] coefficient;
        logic        last_tap;
        int          tap;
    } tap_result_t;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [15:0]      m_tdata;
    logic             m_tlast;
    logic             cfg_we    = 1'b0;
    logic             cfg_addr  = REG_SINC_PERIOD;
    logic [CFG_W-1:0] cfg_wdata = '0;

    pending_t    pending_q[$];
    tap_result_t coef_expected_q[$];

    // Model copy of the block state.
    logic [PER_W-1:0] model_period = 7'd8;
    logic [LOB_W-1:0] model_lobes  = 5'd4;
    logic [TAP_W-1:0] model_tap    = '0;

    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;
    int unsigned tx_gap_pct   = 0;
    int unsigned rx_stall_pct = 0;
    logic        hold_start   = 1'b0;
    logic        rx_hold;

    windowed_sinc_lowpass_coefficients_top #(
        .MAX_LENGTH (MAX_LENGTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // [15:0] window_sample
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),      // [15:0] coefficient
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sin(pi*n/per) in Q2.30 from the quadrant-folded rotation CORDIC.
    function automatic longint tap_sine_q30(input longint n, input longint per);
        longint          two;
        longint          r;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        longint unsigned turn;
        longint unsigned frac;
        two  = 2 * per;
        r    = ((n % two) + two) % two;
        turn = ($unsigned(r) << 32) / $unsigned(two);
        frac = turn & 64'h3FFF_FFFF;
        z    = $signed((frac * HALF_PI_Q30_TB) >> 30);
        x    = GAIN_Q30_TB;
        y    = 0;
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_Q30_TB[k]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_Q30_TB[k]);
            end
        end
        case (turn[31:30])
            2'd0:    return y;
            2'd1:    return x;
            2'd2:    return -y;
            default: return -x;
        endcase
    endfunction

    // sinc in Q1.15 for an offset n from the centre, n never zero.
    function automatic longint tap_sinc_q15(input longint n, input longint per);
        longint          s;
        logic            neg;
        longint unsigned mag_s;
        longint unsigned mag_n;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        s     = tap_sine_q30(n, per);
        neg   = (s < 0) != (n < 0);
        mag_s = (s < 0) ? -s : s;
        mag_n = (n < 0) ? -n : n;
        num   = mag_s * $unsigned(per) * 64'd16384;
        den   = PI_Q29_TB * mag_n;
        q     = (num + den / 2) / den;
        if (neg)
        begin
            if (q > 64'd32768)
                q = 64'd32768;
            return -$signed(q);
        end
        if (q > 64'd32767)
            q = 64'd32767;
        return $signed(q);
    endfunction

    // Expected coefficient for the current tap; advances the tap counter.
    function automatic tap_result_t next_coefficient(input logic [15:0] window);
        longint      w;
        longint      per;
        longint      tap;
        longint      centre;
        longint      last_idx;
        longint      coef;
        logic        at_end;
        tap_result_t res;
        w        = longint'($signed(window));
        per      = longint'(model_period);
        tap      = longint'(model_tap);
        centre   = per * longint'(model_lobes);
        last_idx = 2 * centre;
        if (last_idx > MAX_LENGTH - 1)
            last_idx = MAX_LENGTH - 1;
        at_end = tap >= last_idx;
        if (at_end)
            coef = 0;
        else if (tap == centre)
            coef = w;
        else
        begin
            coef = (w * tap_sinc_q15(tap - centre, per) + 16384) >>> 15;
            if (coef > 32767)
                coef = 32767;
            if (coef < -32768)
                coef = -32768;
        end
        res.coefficient = coef[15:0];
        res.last_tap    = at_end;
        res.tap         = int'(tap);
        model_tap       = at_end ? '0 : model_tap + 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic queue_window(input logic [15:0] window);
        pending_t ent;
        ent        = '{kind: ENT_WINDOW, default: '0};
        ent.window = window;
        pending_q.push_back(ent);
    endtask

    task automatic queue_write(input logic addr, input logic [CFG_W-1:0] value);
        pending_t ent;
        ent       = '{kind: ENT_WRITE, default: '0};
        ent.addr  = addr;
        ent.value = value;
        pending_q.push_back(ent);
    endtask

    task automatic queue_phase(input int unsigned gap, input int unsigned stall);
        pending_t ent;
        ent           = '{kind: ENT_PHASE, default: '0};
        ent.gap_pct   = gap;
        ent.stall_pct = stall;
        pending_q.push_back(ent);
    endtask

    function automatic logic [15:0] pick_window();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random_windows(input int unsigned count);
        for (int unsigned k = 0; k < count; k++)
            queue_window(pick_window());
    endtask

    // Driver: issues window samples and register writes in queue order.
    // A register write only goes out once every issued sample has produced
    // its coefficient, so the block is idle when a register changes.
    always @(posedge clk)
    begin : drive_taps
        logic             nxt_valid;
        logic             nxt_we;
        logic             nxt_addr;
        logic [15:0]      nxt_data;
        logic [CFG_W-1:0] nxt_wdata;
        pending_t         head;
        if (rst_n)
        begin
            nxt_valid = 1'b0;
            nxt_we    = 1'b0;
            nxt_data  = s_tdata;
            nxt_addr  = cfg_addr;
            nxt_wdata = cfg_wdata;
            if (m_tvalid && m_tready)
                results_seen++;
            if (s_tvalid && s_tready)
            begin
                coef_expected_q.push_back(next_coefficient(s_tdata));
                items_sent++;
            end
            if (s_tvalid && !s_tready)
                nxt_valid = 1'b1;
            else
            begin
                while (pending_q.size() != 0 && pending_q[0].kind != ENT_WINDOW
                       && pending_q[0].kind != ENT_WRITE)
                begin
                    head = pending_q.pop_front();
                    if (head.kind == ENT_HOLD)
                        hold_start <= 1'b1;
                    else
                    begin
                        tx_gap_pct   = head.gap_pct;
                        rx_stall_pct = head.stall_pct;
                    end
                end
                if (pending_q.size() != 0)
                begin
                    if (pending_q[0].kind == ENT_WRITE)
                    begin
                        if (items_sent == results_seen)
                        begin
                            head      = pending_q.pop_front();
                            nxt_we    = 1'b1;
                            nxt_addr  = head.addr;
                            nxt_wdata = head.value;
                            if (head.addr == REG_SINC_PERIOD)
                                model_period = head.value[PER_W-1:0];
                            else
                                model_lobes = head.value[LOB_W-1:0];
                        end
                    end
                    else if ($urandom_range(99) >= tx_gap_pct)
                    begin
                        head      = pending_q.pop_front();
                        nxt_valid = 1'b1;
                        nxt_data  = head.window;
                    end
                end
            end
            s_tvalid  <= nxt_valid;
            s_tdata   <= nxt_data;
            cfg_we    <= nxt_we;
            cfg_addr  <= nxt_addr;
            cfg_wdata <= nxt_wdata;
        end
    end

    // Monitor: checks every coefficient transfer and paces m_tready.
    always @(posedge clk)
    begin : check_taps
        tap_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (coef_expected_q.size() == 0)
                    report_mismatch($sformatf("result %h with none expected", m_tdata));
                else
                begin
                    want = coef_expected_q.pop_front();
                    if (m_tdata !== want.coefficient)
                        report_mismatch($sformatf("tap %0d coefficient %h, expected %h",
                                                  want.tap, m_tdata, want.coefficient));
                    if (m_tlast !== want.last_tap)
                        report_mismatch($sformatf("tap %0d last_tap %b, expected %b",
                                                  want.tap, m_tlast, want.last_tap));
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    initial
    begin
        rx_hold = 1'b0;
        wait (hold_start);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("** windowed_sinc_lowpass_coefficients_top: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned      pick;
        int unsigned      len;
        int unsigned      count;
        int unsigned      random_count;
        logic [1:0]       pad;
        logic [PER_W-1:0] gen_period;
        logic [LOB_W-1:0] gen_lobes;
        pending_t         hold_ent;

        // Directed part, no idling.
        queue_phase(0, 0);
        queue_window(16'h7FFF);                 // reset settings, taps 0 and 1
        queue_window(16'h8000);
        queue_write(REG_SINC_PERIOD, 7'd2);
        queue_write(REG_LOBE_COUNT, 7'd2);
        queue_window(16'h0001);                 // taps 2 .. 8, centre at 4
        queue_window(16'hFFFF);
        queue_window(16'h7FFF);
        queue_window(16'h8000);
        queue_window(16'h7FFF);
        queue_window(16'h8000);
        queue_window(16'h1234);                 // final tap
        queue_window(16'h8000);                 // taps 0 .. 5 of the next run
        queue_window(16'h7FFF);
        queue_window(16'h0000);
        queue_window(16'h7FFF);
        queue_window(16'h8000);                 // centre with the most negative window
        queue_window(16'hFFFF);
        // Shrinking the filter leaves the counter past the new end.
        queue_write(REG_LOBE_COUNT, 7'd1);
        queue_window(16'h5A5A);
        // Zero period: every item is a final tap.
        queue_write(REG_SINC_PERIOD, 7'd0);
        queue_window(16'hA5A5);
        queue_window(16'h7FFF);
        // Zero lobes: centre and final tap coincide, the final tap wins.
        queue_write(REG_SINC_PERIOD, 7'd3);
        queue_write(REG_LOBE_COUNT, 7'd0);
        queue_window(16'h7FFF);
        queue_window(16'h8000);
        queue_write(REG_SINC_PERIOD, 7'd1);
        queue_write(REG_LOBE_COUNT, 7'd16);
        queue_window(16'h7FFF);
        queue_window(16'h8000);
        queue_window(16'h7FFF);

        // Receiver hold-off while the sender keeps offering samples.
        queue_phase(0, 0);
        queue_write(REG_SINC_PERIOD, 7'd8);
        queue_write(REG_LOBE_COUNT, 7'd4);
        hold_ent = '{kind: ENT_HOLD, default: '0};
        pending_q.push_back(hold_ent);
        queue_random_windows(130);

        random_count = 0;
        gen_period   = 7'd8;
        gen_lobes    = 5'd4;
        for (int unsigned p = 0; random_count < RANDOM_ITEMS; p++)
        begin
            case (p % 4)
                0:       queue_phase(0, 0);
                1:       queue_phase(45, 0);
                2:       queue_phase(0, 45);
                default: queue_phase(21, 21);
            endcase
            if (p == 6)
            begin
                // Overlong filter at the register maxima: the end is clamped and
                // the centre is never reached, so every offset is far from it.
                queue_write(REG_SINC_PERIOD, 7'h7F);
                queue_write(REG_LOBE_COUNT, 7'h7F);
                gen_period = 7'h7F;
                gen_lobes  = 5'h1F;
                queue_random_windows(LONG_ITEMS);
                random_count += LONG_ITEMS;
                continue;
            end
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                gen_period = PER_W'($urandom_range(1, 8));
                gen_lobes  = LOB_W'($urandom_range(1, 4));
            end
            else if (pick < 65)
            begin
                gen_period = PER_W'($urandom_range(1, 64));
                gen_lobes  = 5'd1;
            end
            else if (pick < 75)
            begin
                gen_period = 7'd1;
                gen_lobes  = LOB_W'($urandom_range(1, 16));
            end
            else if (pick < 82)
            begin
                if ($urandom_range(1) == 0)
                    gen_period = 7'd0;
                else
                    gen_lobes = 5'd0;
            end
            else if (pick < 90)
            begin
                gen_period = PER_W'($urandom_range(64, 127));
                gen_lobes  = 5'd1;
            end
            else
                gen_period = PER_W'($urandom_range(1, 8));
            queue_write(REG_SINC_PERIOD, gen_period);
            if (pick < 90)
            begin
                // The upper write data bits are outside the lobe register.
                pad = 2'($urandom_range(3));
                queue_write(REG_LOBE_COUNT, {pad, gen_lobes});
            end
            len = 2 * gen_period * gen_lobes;
            if (len > MAX_LENGTH - 1)
                len = MAX_LENGTH - 1;
            len = len + 1;
            if (len == 1)
                count = $urandom_range(1, 4);
            else if ($urandom_range(99) < 20)
                count = $urandom_range(1, len);
            else if (len > 64)
                count = len;
            else
                count = len * $urandom_range(1, 3);
            queue_random_windows(count);
            random_count += count;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_q.size() != 0 || s_tvalid || coef_expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (coef_expected_q.size() != 0)
            report_mismatch($sformatf("%0d coefficients never arrived",
                                      coef_expected_q.size()));
        if (mismatches == 0)
            $display("** windowed_sinc_lowpass_coefficients_top: PASSED **");
        else
            $display("** windowed_sinc_lowpass_coefficients_top: FAILED **");
        $finish;
    end

endmodule
